// ===== sv/avcc_to_annexb_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_extractor_macros.svh
// Assertion macros used by the extractor top module.
// ----------------------------------------------------------------------------
`ifndef AVCC_TO_ANNEXB_EXTRACTOR_MACROS_SVH
`define AVCC_TO_ANNEXB_EXTRACTOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define A2AB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2ab assertion failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define A2AB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2ab assertion failed");

`endif

// ===== sv/a2ab_pkg.sv =====
// ----------------------------------------------------------------------------
// a2ab_pkg
// Types and codes for the avcC to Annex B extractor.
// ----------------------------------------------------------------------------
package a2ab_pkg;

    typedef enum logic [3:0] {
        PH_HEAD     = 4'd0,
        PH_SPS_HI   = 4'd1,
        PH_SPS_LO   = 4'd2,
        PH_SPS_DATA = 4'd3,
        PH_PPS_CNT  = 4'd4,
        PH_PPS_HI   = 4'd5,
        PH_PPS_LO   = 4'd6,
        PH_PPS_DATA = 4'd7,
        PH_TRAIL    = 4'd8,
        PH_ANNEXB   = 4'd9,
        PH_SINK     = 4'd10
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ANNEXB    = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [7:0] VERSION_ONE  = 8'h01;
    localparam logic [2:0] POS_MAX      = 3'd7;

    // Results that one input byte causes, handed from parser to emitter.
    typedef struct packed {
        logic       sc;        // four start code bytes
        logic       sc_empty;  // zero length unit: last start code byte ends it
        logic       dat;       // one parameter set byte
        logic [7:0] byte_val;
        logic       sec;
        logic       dat_end;
        logic       stat;      // status result follows the bytes
        logic [1:0] st;
    } desc_t;

endpackage

// ===== sv/a2ab_parser.sv =====
// ----------------------------------------------------------------------------
// a2ab_parser
// Record state machine: updates on each accepted byte and describes the
// results that byte causes.
// ----------------------------------------------------------------------------
module a2ab_parser
    import a2ab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output desc_t      desc,
    output logic       desc_any
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] rem_reg,    rem_next;
    logic [23:0] prefix_reg, prefix_next;
    logic        err_reg,    err_next;

    logic [15:0] len_full;
    logic [15:0] rem_dec;
    logic        sec_pps;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            pos_reg    <= '0;
            len_hi_reg <= '0;
            rem_reg    <= '0;
            prefix_reg <= '0;
            err_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_hi_reg <= len_hi_next;
            rem_reg    <= rem_next;
            prefix_reg <= prefix_next;
            err_reg    <= err_next;
        end
    end

    assign len_full = {len_hi_reg, in_byte};
    assign rem_dec  = (rem_reg != 16'd0) ? rem_reg - 16'd1 : 16'd0;
    assign sec_pps  = (phase_reg == PH_PPS_LO) || (phase_reg == PH_PPS_DATA);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 3'd1;
        len_hi_next = len_hi_reg;
        rem_next    = rem_reg;
        prefix_next = prefix_reg;
        err_next    = err_reg;
        desc        = '0;

        case (phase_reg)
            PH_HEAD:
            begin
                if (pos_reg == 3'd0)
                    err_next = (in_byte != VERSION_ONE);
                if (pos_reg < 3'd3)
                    prefix_next = {prefix_reg[15:0], in_byte};
                else if (pos_reg == 3'd3)
                begin
                    // 00 00 00 01 or 00 00 01 at the head
                    if (((prefix_reg == 24'd0) && (in_byte == 8'd1)) ||
                        (prefix_reg == 24'd1))
                        phase_next = PH_ANNEXB;
                    else if (err_reg)
                        phase_next = PH_SINK;
                end
                else if (pos_reg >= 3'd5)
                    phase_next = PH_SPS_HI;
            end
            PH_SPS_HI:
            begin
                len_hi_next = in_byte;
                phase_next  = PH_SPS_LO;
            end
            PH_PPS_HI:
            begin
                len_hi_next = in_byte;
                phase_next  = PH_PPS_LO;
            end
            PH_SPS_LO, PH_PPS_LO:
            begin
                rem_next      = len_full;
                desc.sc       = 1'b1;
                desc.sc_empty = (len_full == 16'd0);
                desc.sec      = sec_pps;
                if (len_full != 16'd0)
                    phase_next = sec_pps ? PH_PPS_DATA : PH_SPS_DATA;
                else
                    phase_next = sec_pps ? PH_TRAIL : PH_PPS_CNT;
            end
            PH_SPS_DATA, PH_PPS_DATA:
            begin
                rem_next      = rem_dec;
                desc.dat      = 1'b1;
                desc.byte_val = in_byte;
                desc.sec      = sec_pps;
                desc.dat_end  = (rem_dec == 16'd0);
                if (rem_dec == 16'd0)
                    phase_next = sec_pps ? PH_TRAIL : PH_PPS_CNT;
            end
            PH_PPS_CNT:
                phase_next = PH_PPS_HI;
            default:
                ;
        endcase

        if (in_final)
        begin
            desc.stat = 1'b1;
            if (phase_next == PH_ANNEXB)
                desc.st = ST_ANNEXB;
            else if ((phase_next == PH_TRAIL) && !err_next)
                desc.st = ST_OK;
            else
                desc.st = ST_MALFORMED;
            // back to reset state for the next record
            phase_next  = PH_HEAD;
            pos_next    = '0;
            len_hi_next = '0;
            rem_next    = '0;
            prefix_next = '0;
            err_next    = 1'b0;
        end
    end

    assign desc_any = desc.sc | desc.dat | desc.stat;

endmodule

// ===== sv/a2ab_emitter.sv =====
// ----------------------------------------------------------------------------
// a2ab_emitter
// Result register: holds one byte's results and hands them out one per
// cycle while out_ready is high; reloads when empty or as the last leaves.
// ----------------------------------------------------------------------------
module a2ab_emitter
    import a2ab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  desc_t      desc,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       has_byte,
    output logic [7:0] out_byte,
    output logic       section,
    output logic       unit_end,
    output logic       has_status,
    output logic [1:0] status
);

    logic [2:0] sc_left_reg;
    logic       dat_reg;
    logic       stat_reg;
    logic [7:0] byte_reg;
    logic       sec_reg;
    logic       dend_reg;
    logic       scend_reg;
    logic [1:0] st_reg;

    logic [2:0] cnt;
    logic       fire;

    assign cnt       = sc_left_reg + {2'b00, dat_reg} + {2'b00, stat_reg};
    assign out_valid = (cnt != 3'd0);
    assign fire      = out_valid && out_ready;
    assign free      = (cnt == 3'd0) || (out_ready && (cnt == 3'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_left_reg <= '0;
            dat_reg     <= 1'b0;
            stat_reg    <= 1'b0;
        end
        else if (load)
        begin
            sc_left_reg <= desc.sc ? 3'd4 : 3'd0;
            dat_reg     <= desc.dat;
            stat_reg    <= desc.stat;
        end
        else if (fire)
        begin
            if (sc_left_reg != 3'd0)
                sc_left_reg <= sc_left_reg - 3'd1;
            else if (dat_reg)
                dat_reg <= 1'b0;
            else
                stat_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= desc.byte_val;
            sec_reg   <= desc.sec;
            dend_reg  <= desc.dat_end;
            scend_reg <= desc.sc_empty;
            st_reg    <= desc.st;
        end
    end

    always_comb
    begin
        has_byte   = 1'b0;
        out_byte   = 8'd0;
        section    = 1'b0;
        unit_end   = 1'b0;
        has_status = 1'b0;
        status     = ST_OK;
        if (sc_left_reg != 3'd0)
        begin
            // start code 00 00 00 01, last byte when one is left
            has_byte = 1'b1;
            out_byte = (sc_left_reg == 3'd1) ? 8'd1 : 8'd0;
            section  = sec_reg;
            unit_end = (sc_left_reg == 3'd1) && scend_reg;
        end
        else if (dat_reg)
        begin
            has_byte = 1'b1;
            out_byte = byte_reg;
            section  = sec_reg;
            unit_end = dend_reg;
        end
        else if (stat_reg)
        begin
            has_status = 1'b1;
            status     = st_reg;
        end
    end

endmodule

// ===== sv/avcc_to_annexb_extractor.sv =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_extractor
// Extracts the first SPS and PPS of an avcC record as Annex B units.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_*     | in  | tdata[7:0] record byte, tlast final byte of record
//  m_*     | out | tdata byte/status, tuser kind flags, tlast unit end
//
//  One record byte is taken per cycle while the result register keeps up.
//  A length low byte yields five results at most (start code + status), so
//  it holds the input until they leave, as does a final data byte.
//  Ready comes from the result register: it is free, or its last pending
//  result leaves this cycle. Reset (rst_n low, async) returns to header.
// ----------------------------------------------------------------------------
`include "avcc_to_annexb_extractor_macros.svh"

module avcc_to_annexb_extractor
    import a2ab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, rest zero
    output logic [2:0]  m_tuser,   // [0] has_byte, [1] section, [2] has_status
    output logic        m_tlast    // unit_end
);

    desc_t      desc;
    logic       desc_any;
    logic       take;
    logic       free;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       section;
    logic       unit_end;
    logic       has_status;
    logic [1:0] status;

    assign s_tready = free;
    assign take     = s_tvalid && free;

    a2ab_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .desc     (desc),
        .desc_any (desc_any)
    );

    a2ab_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && desc_any),
        .desc       (desc),
        .free       (free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .has_byte   (has_byte),
        .out_byte   (out_byte),
        .section    (section),
        .unit_end   (unit_end),
        .has_status (has_status),
        .status     (status)
    );

    assign m_tdata = {6'd0, status, out_byte};
    assign m_tuser = {has_status, section, has_byte};
    assign m_tlast = unit_end;

    `A2AB_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready)
    `A2AB_ASSERT_NOW(a_status_no_byte, m_tvalid && has_status, !has_byte && !unit_end)
    `A2AB_ASSERT_NOW(a_end_on_byte, m_tvalid && unit_end, has_byte)
    `A2AB_ASSERT_NOW(a_status_code, m_tvalid && has_status, status != 2'd3)
    `A2AB_ASSERT_NEXT(a_sc_holds, m_tvalid && has_byte && !m_tready, m_tvalid && has_byte)

endmodule
